/* design/rpdf_pkg.sv */
// ----------------------------------------------------------------------------
// rpdf_pkg
// Shared sizes, types and control structs for the recent packet duplicate
// filter.
// ----------------------------------------------------------------------------
package rpdf_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SRC_W   = 32;
	localparam int TIME_W  = 64;
	localparam int CAP_W   = 7;
	localparam int ENTRY_W = SRC_W + TIME_W;
	// width that holds both the capacity register and any slot count
	localparam int CW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic FUNC_CHECK = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef logic [SRC_W-1:0]   src_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [CW-1:0]      cnt_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch the request payload
		logic clear;       // empty the history
		logic scan_start;  // rewind the scan index
		logic scan;        // walk the history
		logic write;       // record the request as newest
		logic res_set;     // capture the result bit
		logic res_val;
		logic out_load;    // move the result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;    // request at the input is a clear
		logic empty;       // no entries to search
		logic hit;         // a searched entry matches
		logic miss_done;   // last entry searched without a match
		logic out_free;    // output register can take a result
	} sts_t;

endpackage

/* design/rpdf_req_if.sv */
// ----------------------------------------------------------------------------
// rpdf_req_if
// Request channel: check or clear, with source identifier and timestamp.
// ----------------------------------------------------------------------------
interface rpdf_req_if import rpdf_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  func;
	src_t  source_id;
	time_t packet_time;

	modport source (output valid, func, source_id, packet_time, input ready);
	modport sink   (input valid, func, source_id, packet_time, output ready);
endinterface

/* design/rpdf_rsp_if.sv */
// ----------------------------------------------------------------------------
// rpdf_rsp_if
// Result channel: one is_new bit per request.
// ----------------------------------------------------------------------------
interface rpdf_rsp_if;
	logic valid;
	logic ready;
	logic is_new;

	modport source (output valid, is_new, input ready);
	modport sink   (input valid, is_new, output ready);
endinterface

/* design/rpdf_cfg_if.sv */
// ----------------------------------------------------------------------------
// rpdf_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface rpdf_cfg_if import rpdf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

/* design/rpdf_ram.sv */
// ----------------------------------------------------------------------------
// rpdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/rpdf_ctrl.sv */
// ----------------------------------------------------------------------------
// rpdf_ctrl
// Sequencer: accept a request, clear or scan the history, record on a miss, hand the
// result to the output register.
// ----------------------------------------------------------------------------
module rpdf_ctrl import rpdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (sts.is_clear) begin
						cmd.clear   = 1'b1;
						cmd.res_set = 1'b1;
						cmd.res_val = 1'b0;
						state_d     = ST_DONE;
					end else if (sts.empty) begin
						state_d = ST_WR;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.res_set = 1'b1;
					cmd.res_val = 1'b0;
					state_d     = ST_DONE;
				end else if (sts.miss_done) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				cmd.write   = 1'b1;
				cmd.res_set = 1'b1;
				cmd.res_val = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/rpdf_dp.sv */
// ----------------------------------------------------------------------------
// rpdf_dp
// Datapath: request latch, history RAM, scan pipeline, fill and replacement
// counters, capacity register and output register.
// ----------------------------------------------------------------------------
module rpdf_dp import rpdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_func,
	input  src_t             req_source_id,
	input  time_t            req_packet_time,
	input  logic             cfg_valid,
	input  logic [CAP_W-1:0] cfg_capacity,
	input  logic             rsp_ready,
	output logic             rsp_valid,
	output logic             rsp_is_new,
	input  cmd_t             cmd,
	output sts_t             sts
);

	src_t             src_q;
	time_t            time_q;
	logic [CAP_W-1:0] cap_q;
	cnt_t             fill_q;
	cnt_t             wp_q;
	cnt_t             idx_q;
	logic             rd_v_s1;
	logic             last_s1;
	logic             res_q;
	logic             out_valid_q;
	logic             is_new_q;

	cnt_t   cap_eff;
	cnt_t   vcnt;
	cnt_t   idx_inc;
	logic   issue;
	cnt_t   slot;
	cnt_t   slot_inc;
	cnt_t   fill_d;
	cnt_t   wp_d;
	entry_t rdata;
	logic   match;

	// clamp capacity to 1..DEPTH
	always_comb begin
		cap_eff = CW'(cap_q);
		if (cap_eff == '0) begin
			cap_eff = CW'(1);
		end
		if (cap_eff > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end
	end

	assign vcnt    = (fill_q < cap_eff) ? fill_q : cap_eff;
	assign idx_inc = idx_q + CW'(1);
	assign issue   = cmd.scan && (idx_q < vcnt);

	// slot choice and counter update for a record
	always_comb begin
		if (fill_q < cap_eff) begin
			slot     = fill_q;
			slot_inc = fill_q + CW'(1);
			fill_d   = slot_inc;
		end else begin
			slot     = (wp_q < cap_eff) ? wp_q : '0;
			slot_inc = slot + CW'(1);
			fill_d   = cap_eff;
		end
		wp_d = (slot_inc >= cap_eff) ? '0 : slot_inc;
	end

	rpdf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (slot[ADDR_W-1:0]),
		.wdata ({src_q, time_q}),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign match = rd_v_s1 && (rdata == {src_q, time_q});

	assign sts.is_clear  = (req_func == FUNC_CLEAR);
	assign sts.empty     = (vcnt == '0);
	assign sts.hit       = match;
	assign sts.miss_done = rd_v_s1 && last_s1 && !match;
	assign sts.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_is_new = is_new_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q  <= req_source_id;
			time_q <= req_packet_time;
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_val;
		end
		if (cmd.out_load) begin
			is_new_q <= res_q;
		end
		last_s1 <= (idx_inc == vcnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			fill_q      <= '0;
			wp_q        <= '0;
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_capacity;
			end
			if (cmd.clear) begin
				fill_q <= '0;
				wp_q   <= '0;
			end else if (cmd.write) begin
				fill_q <= fill_d;
				wp_q   <= wp_d;
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_inc;
			end
			rd_v_s1 <= issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/recent_packet_duplicate_filter_top.sv */
// ----------------------------------------------------------------------------
// recent_packet_duplicate_filter_top
// Flags repeated packets against a FIFO history of recent (source, time) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req carries func (check or clear), source_id and packet_time; rsp returns
//   one is_new bit per request; cfg writes the capacity register (reset 64,
//   0 acts as 1, above 64 acts as 64). Write cfg only while no request is in
//   flight.
//   A check reads the history RAM one entry per cycle through its single
//   registered read port and stops at the first match. One request is
//   handled at a time; the next is accepted when the previous result sits
//   in the output register.
//   Reset empties the history; no clearing pass is needed since only written
//   slots are searched.
//   When rsp stalls, the finished result holds in the output register and
//   the next request may still be taken and searched; its result waits until
//   the register frees.
// ----------------------------------------------------------------------------
module recent_packet_duplicate_filter_top import rpdf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	rpdf_req_if.sink req,
	rpdf_rsp_if.source rsp,
	rpdf_cfg_if.sink cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	rpdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpdf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_func        (req.func),
		.req_source_id   (req.source_id),
		.req_packet_time (req.packet_time),
		.cfg_valid       (cfg.valid),
		.cfg_capacity    (cfg.capacity),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_is_new      (rsp.is_new),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule

/* design/rpdf_checker.sv */
// ----------------------------------------------------------------------------
// rpdf_checker
// Port-level checks on the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
module rpdf_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_func,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_is_new
);

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted back to back");

	// a clear into an empty output answers through the done state and the output register with is_new low
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_func && !rsp_valid) |=> ##1
		(rsp_valid && !rsp_is_new))
		else $error("clear did not answer with is_new low");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp_is_new))
		else $error("result changed while stalled");

endmodule

bind recent_packet_duplicate_filter_top rpdf_checker u_rpdf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_func   (req.func),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_is_new (rsp.is_new)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recent packet duplicate filter. Sends check and
// clear requests with random gaps and response stalls under several capacity
// settings, predicts each is_new bit from a local copy of the history, and
// compares every response in order.
// ----------------------------------------------------------------------------
module tb_top import rpdf_pkg::*; ();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = DEPTH + 16;
	localparam int POOL_MAX     = 200;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 85;

	class history_predictor;
		src_t             src_hist[DEPTH];
		time_t            time_hist[DEPTH];
		int unsigned      fill;
		int unsigned      wr_ptr;
		logic [CAP_W-1:0] capacity;
		bit               expected_is_new[$];
		int unsigned      errors;

		function new();
			fill     = 0;
			wr_ptr   = 0;
			capacity = CAP_RESET;
			errors   = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function int unsigned pending();
			return expected_is_new.size();
		endfunction

		function void note_request(logic func, src_t source_id, time_t packet_time);
			int unsigned cap;
			int unsigned searched;
			int unsigned slot;
			int unsigned i;
			if (func == FUNC_CLEAR) begin
				fill   = 0;
				wr_ptr = 0;
				expected_is_new.push_back(1'b0);
				return;
			end
			cap = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
			// a lowered capacity hides the slots above it
			searched = (fill < cap) ? fill : cap;
			for (i = 0; i < searched; i++) begin
				if (src_hist[i] == source_id && time_hist[i] == packet_time) begin
					expected_is_new.push_back(1'b0);
					return;
				end
			end
			if (fill < cap) begin
				slot   = fill;
				fill   = fill + 1;
				wr_ptr = (fill >= cap) ? 0 : fill;
			end else begin
				slot   = (wr_ptr < cap) ? wr_ptr : 0;
				wr_ptr = (slot + 1 >= cap) ? 0 : slot + 1;
				fill   = cap;
			end
			src_hist[slot]  = source_id;
			time_hist[slot] = packet_time;
			expected_is_new.push_back(1'b1);
		endfunction

		function void compare_is_new(logic actual);
			bit expected;
			if (expected_is_new.size() == 0) begin
				$display("%0t: response with none outstanding: expected none actual is_new=%0b",
					$time, actual);
				errors++;
				return;
			end
			expected = expected_is_new.pop_front();
			if (actual !== expected) begin
				$display("%0t: is_new mismatch: expected %0b actual %0b", $time, expected, actual);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	bit               steady;
	int unsigned      cycles = 0;
	history_predictor hist_pred = new();
	src_t             seen_src[$];
	time_t            seen_time[$];
	logic [CAP_W-1:0] phase_caps [PHASES] = '{7'd1, 7'd2, 7'd5, 7'd64, 7'd0,
		7'd3, 7'd127, 7'd33, 7'd65, 7'd8};

	rpdf_req_if req();
	rpdf_rsp_if rsp();
	rpdf_cfg_if cfg();

	recent_packet_duplicate_filter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				hist_pred.set_capacity(cfg.capacity);
			if (req.valid && req.ready)
				hist_pred.note_request(req.func, req.source_id, req.packet_time);
			if (rsp.valid && rsp.ready)
				hist_pred.compare_is_new(rsp.is_new);
		end
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady || ($urandom_range(0, 99) >= 33);
		end
	end

	// leave valid high on return so back-to-back requests need no second update
	task automatic send_request(logic func, src_t source_id, time_t packet_time);
		while (!steady && $urandom_range(0, 99) < 33) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.func        <= func;
		req.source_id   <= source_id;
		req.packet_time <= packet_time;
		do @(posedge clk); while (!req.ready);
		if (func == FUNC_CHECK) begin
			seen_src.push_back(source_id);
			seen_time.push_back(packet_time);
			if (seen_src.size() > POOL_MAX) begin
				void'(seen_src.pop_front());
				void'(seen_time.pop_front());
			end
		end
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (hist_pred.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		cfg.valid    <= 1'b1;
		cfg.capacity <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_random();
		int unsigned pick;
		int unsigned span;
		int unsigned idx;
		src_t        s;
		time_t       t;
		pick = $urandom_range(0, 99);
		s    = $urandom;
		t    = {$urandom, $urandom};
		if (pick < 5) begin
			send_request(FUNC_CLEAR, s, t);
		end else if (pick < 55 && seen_src.size() > 0) begin
			// replay a recent packet; some fall out of the history first
			span = 3 * hist_pred.capacity + 4;
			if (span > seen_src.size())
				span = seen_src.size();
			idx = seen_src.size() - 1 - $urandom_range(0, span - 1);
			s   = seen_src[idx];
			t   = seen_time[idx];
			if (pick < 12)
				s[$urandom_range(0, SRC_W - 1)] = ~s[$urandom_range(0, SRC_W - 1)];
			else if (pick < 18)
				t[$urandom_range(0, TIME_W - 1)] = ~t[$urandom_range(0, TIME_W - 1)];
			send_request(FUNC_CHECK, s, t);
		end else begin
			if (pick >= 92) begin
				s = $urandom_range(0, 3);
				case ($urandom_range(0, 3))
					0: t = '0;
					1: t = 64'h8000_0000_0000_0000;
					2: t = '1;
					default: t = 64'h7FF8_0000_0000_0001;
				endcase
			end
			send_request(FUNC_CHECK, s, t);
		end
	endtask

	initial begin
		int unsigned i;
		int unsigned p;
		int unsigned n;
		steady          = 1'b0;
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.func        <= FUNC_CHECK;
		req.source_id   <= '0;
		req.packet_time <= '0;
		cfg.valid       <= 1'b0;
		cfg.capacity    <= CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FUNC_CHECK, 32'h0, 64'h0);
		send_request(FUNC_CHECK, 32'h0, 64'h0);
		// negative zero is a different pattern
		send_request(FUNC_CHECK, 32'h0, 64'h8000_0000_0000_0000);
		send_request(FUNC_CHECK, '1, '1);
		// NaN pattern matches itself
		send_request(FUNC_CHECK, '1, 64'h7FF8_0000_0000_0001);
		send_request(FUNC_CHECK, '1, 64'h7FF8_0000_0000_0001);
		send_request(FUNC_CHECK, '1, 64'h0);
		send_request(FUNC_CHECK, 32'h1, 64'h0);
		send_request(FUNC_CLEAR, '1, '1);
		send_request(FUNC_CHECK, 32'h0, 64'h0);
		for (i = 1; i <= 4; i++)
			send_request(FUNC_CHECK, 32'h100 + i, time_t'(i));
		// drop capacity below the fill level
		write_capacity(7'd2);
		send_request(FUNC_CHECK, 32'h0, 64'h0);
		send_request(FUNC_CHECK, 32'h103, time_t'(3));
		send_request(FUNC_CHECK, 32'h0, 64'h0);
		send_request(FUNC_CHECK, 32'h103, time_t'(3));
		write_capacity(7'd8);
		send_request(FUNC_CHECK, 32'h102, time_t'(2));
		// zero acts as one entry
		write_capacity(7'd0);
		send_request(FUNC_CHECK, 32'h55, time_t'(5));
		send_request(FUNC_CHECK, 32'h55, time_t'(5));
		send_request(FUNC_CHECK, 32'h102, time_t'(2));
		write_capacity(7'd127);
		send_request(FUNC_CHECK, 32'h102, time_t'(2));
		send_request(FUNC_CHECK, 32'h55, time_t'(5));

		for (p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			steady = (p == 3);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold requests until every response is back
				if (p == 5 && n == 40)
					wait_idle();
				send_random();
			end
		end
		steady = 1'b0;

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (hist_pred.errors == 0 && hist_pred.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* recent_packet_duplicate_filter_top.f */
design/rpdf_pkg.sv
design/rpdf_req_if.sv
design/rpdf_rsp_if.sv
design/rpdf_cfg_if.sv
design/rpdf_ram.sv
design/rpdf_ctrl.sv
design/rpdf_dp.sv
design/recent_packet_duplicate_filter_top.sv
design/rpdf_checker.sv
test/tb_top.sv
